// ===== hw/rtl/sppf_pkg.sv =====
package sppf_pkg;

	localparam int POS_W    = 20;
	localparam int MAG_W    = POS_W;
	localparam int MASS_W   = 16;
	localparam int DENS_W   = 32;
	localparam int PR_W     = 32;
	localparam int PS_W     = PR_W + 1;
	localparam int MP_W     = MASS_W + PS_W;
	localparam int H_W      = 19;
	localparam int HSQ_W    = 2 * H_W;
	localparam int D2_W     = 2 * MAG_W + 1;
	localparam int F_W      = 48;

	// Q0.32 fractions with one bit of headroom for the value 1.0
	localparam int FR_W     = 33;
	localparam int FR_FRAC  = 32;

	localparam int SQ_IN_W  = 56;
	localparam int SQ_OUT_W = SQ_IN_W / 2;
	localparam int SQ_REM_W = SQ_OUT_W + 2;
	localparam int SQ_LAT   = SQ_OUT_W;
	localparam int RAD_SH   = 16;

	localparam int DIV_N_W  = 64;
	localparam int DIV_D_W  = 32;
	localparam int DIV_LAT  = DIV_N_W;

	localparam int R_SH     = 24;
	localparam int C_SH     = 40;
	localparam int G_SH     = 20;
	localparam int SC_SH    = 16;
	localparam int G_W      = 55;
	localparam int GX5_W    = FR_W + 2;

	localparam int PP_W     = 32;
	localparam int PROD_W   = DIV_N_W + G_W + 1;
	localparam int F_SH     = 50;
	localparam int FMAG_W   = PROD_W - F_SH;

	localparam int M_LAT    = 5;
	localparam int FM_LAT   = 4;
	localparam int CTL_LAT  = SQ_LAT + DIV_LAT + M_LAT + DIV_LAT + FM_LAT;
	localparam int SC_DLY   = SQ_LAT + M_LAT + DIV_LAT;
	localparam int MUL_TAP  = CTL_LAT - FM_LAT - 1;

	localparam logic [H_W-1:0]   CUTOFF_RST = H_W'(12800);
	localparam logic [HSQ_W-1:0] HSQ_RST    = HSQ_W'(CUTOFF_RST) * HSQ_W'(CUTOFF_RST);
	localparam logic [FR_W-1:0]  FR_ONE     = FR_W'(1) << FR_FRAC;

	typedef struct packed {
		logic v;
		logic negx;
		logic negy;
		logic psneg;
		logic kill;
		logic zden;
	} ctl_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_OUT_W-1:0] root;
	} sq_st_t;

	typedef struct packed {
		logic [DIV_N_W-1:0] nq;
		logic [DIV_D_W-1:0] rem;
	} div_st_t;

	function automatic sq_st_t sq_step(sq_st_t st, logic [1:0] b);
		logic [SQ_REM_W+1:0] r4;
		logic [SQ_REM_W+1:0] t;
		sq_st_t o;
		r4 = {st.rem, b};
		t  = (SQ_REM_W + 2)'({st.root, 2'b01});
		if (r4 >= t) begin
			o.rem  = SQ_REM_W'(r4 - t);
			o.root = {st.root[SQ_OUT_W-2:0], 1'b1};
		end else begin
			o.rem  = r4[SQ_REM_W-1:0];
			o.root = {st.root[SQ_OUT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic div_st_t div_step(div_st_t st, logic [DIV_D_W-1:0] den);
		logic [DIV_D_W:0] t;
		div_st_t o;
		t = {st.rem, st.nq[DIV_N_W-1]};
		if (t >= {1'b0, den}) begin
			o.rem = DIV_D_W'(t - {1'b0, den});
			o.nq  = {st.nq[DIV_N_W-2:0], 1'b1};
		end else begin
			o.rem = t[DIV_D_W-1:0];
			o.nq  = {st.nq[DIV_N_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [FR_W-1:0] fr_mul(logic [FR_W-1:0] a, logic [FR_W-1:0] b);
		logic [2*FR_W-1:0] p;
		p = (2 * FR_W)'(a) * (2 * FR_W)'(b);
		return p[FR_W+FR_FRAC-1:FR_FRAC];
	endfunction

endpackage

// ===== hw/rtl/sppf_ifs.sv =====
interface sppf_pair_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sppf_pkg::POS_W-1:0]    pos_i_x;
	logic signed [sppf_pkg::POS_W-1:0]    pos_i_y;
	logic signed [sppf_pkg::POS_W-1:0]    pos_j_x;
	logic signed [sppf_pkg::POS_W-1:0]    pos_j_y;
	logic        [sppf_pkg::MASS_W-1:0]   mass_j;
	logic        [sppf_pkg::DENS_W-1:0]   density_j;
	logic signed [sppf_pkg::PR_W-1:0]     pressure_ratio_i;
	logic signed [sppf_pkg::PR_W-1:0]     pressure_ratio_j;

	modport source (output valid, pos_i_x, pos_i_y, pos_j_x, pos_j_y, mass_j, density_j,
		pressure_ratio_i, pressure_ratio_j, input ready);
	modport sink (input valid, pos_i_x, pos_i_y, pos_j_x, pos_j_y, mass_j, density_j,
		pressure_ratio_i, pressure_ratio_j, output ready);
endinterface

interface sppf_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [sppf_pkg::F_W-1:0]  force_x;
	logic signed [sppf_pkg::F_W-1:0]  force_y;
	logic                             zero_density_flag;
	logic                             saturated_flag;

	modport source (output valid, force_x, force_y, zero_density_flag, saturated_flag,
		input ready);
	modport sink (input valid, force_x, force_y, zero_density_flag, saturated_flag,
		output ready);
endinterface

// ===== hw/rtl/sppf_sqrt_pipe.sv =====
module sppf_sqrt_pipe (
	input  logic                            clk,
	input  logic                            en,
	input  logic [sppf_pkg::SQ_IN_W-1:0]    rad,
	output logic [sppf_pkg::SQ_OUT_W-1:0]   root
);

	sppf_pkg::sq_st_t                    st_s  [sppf_pkg::SQ_LAT];
	sppf_pkg::sq_st_t                    st_d  [sppf_pkg::SQ_LAT];
	logic [sppf_pkg::SQ_IN_W-1:0]        rad_s [sppf_pkg::SQ_LAT];
	logic [sppf_pkg::SQ_IN_W-1:0]        rad_d [sppf_pkg::SQ_LAT];

	// one root bit per stage, radicand consumed two bits at a time
	always_comb begin
		for (int k = 0; k < sppf_pkg::SQ_LAT; k++) begin
			if (k == 0) begin
				st_d[k]  = sppf_pkg::sq_step('0, rad[sppf_pkg::SQ_IN_W-1 -: 2]);
				rad_d[k] = rad << 2;
			end else begin
				st_d[k]  = sppf_pkg::sq_step(st_s[k-1], rad_s[k-1][sppf_pkg::SQ_IN_W-1 -: 2]);
				rad_d[k] = rad_s[k-1] << 2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sppf_pkg::SQ_LAT; k++) begin
				st_s[k]  <= st_d[k];
				rad_s[k] <= rad_d[k];
			end
		end
	end

	assign root = st_s[sppf_pkg::SQ_LAT-1].root;

endmodule

// ===== hw/rtl/sppf_div_pipe.sv =====
module sppf_div_pipe (
	input  logic                            clk,
	input  logic                            en,
	input  logic [sppf_pkg::DIV_N_W-1:0]    num,
	input  logic [sppf_pkg::DIV_D_W-1:0]    den,
	output logic [sppf_pkg::DIV_N_W-1:0]    quo
);

	sppf_pkg::div_st_t                   st_s  [sppf_pkg::DIV_LAT];
	sppf_pkg::div_st_t                   st_d  [sppf_pkg::DIV_LAT];
	logic [sppf_pkg::DIV_D_W-1:0]        den_s [sppf_pkg::DIV_LAT];
	logic [sppf_pkg::DIV_D_W-1:0]        den_d [sppf_pkg::DIV_LAT];

	// restoring division, one quotient bit per stage
	always_comb begin
		for (int k = 0; k < sppf_pkg::DIV_LAT; k++) begin
			if (k == 0) begin
				den_d[k] = den;
				st_d[k]  = sppf_pkg::div_step('{nq: num, rem: '0}, den);
			end else begin
				den_d[k] = den_s[k-1];
				st_d[k]  = sppf_pkg::div_step(st_s[k-1], den_s[k-1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < sppf_pkg::DIV_LAT; k++) begin
				st_s[k]  <= st_d[k];
				den_s[k] <= den_d[k];
			end
		end
	end

	assign quo = st_s[sppf_pkg::DIV_LAT-1].nq;

endmodule

// ===== hw/rtl/sppf_force_mul.sv =====
module sppf_force_mul (
	input  logic                            clk,
	input  logic                            en,
	input  logic [sppf_pkg::DIV_N_W-1:0]    sc,
	input  logic [sppf_pkg::G_W-1:0]        g,
	input  logic                            neg,
	output logic [sppf_pkg::F_W-1:0]        f,
	output logic                            sat
);

	localparam int PP = sppf_pkg::PP_W;
	localparam int GH = sppf_pkg::G_W - PP;
	localparam int AW = 2 * PP + PP + 1;
	localparam int BW = PP + GH + PP + 1;
	localparam int PW = sppf_pkg::PROD_W;
	localparam int MW = sppf_pkg::FMAG_W;

	logic [2*PP-1:0]     ll_s1, hl_s1;
	logic [PP+GH-1:0]    lh_s1, hh_s1;
	logic                neg_s1, neg_s2, neg_s3;
	logic [AW-1:0]       a_s2;
	logic [BW-1:0]       b_s2;
	logic [PW-1:0]       prod_s3;
	logic [MW-1:0]       mag, lim, magc;
	logic                ovf;
	logic [sppf_pkg::F_W-1:0] f_s4;
	logic                sat_s4;

	always_comb begin
		mag  = prod_s3[PW-1:sppf_pkg::F_SH];
		lim  = neg_s3 ? (MW'(1) << (sppf_pkg::F_W - 1))
			: ((MW'(1) << (sppf_pkg::F_W - 1)) - MW'(1));
		ovf  = mag > lim;
		magc = ovf ? lim : mag;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= (2 * PP)'(sc[PP-1:0]) * (2 * PP)'(g[PP-1:0]);
			hl_s1   <= (2 * PP)'(sc[2*PP-1:PP]) * (2 * PP)'(g[PP-1:0]);
			lh_s1   <= (PP + GH)'(sc[PP-1:0]) * (PP + GH)'(g[sppf_pkg::G_W-1:PP]);
			hh_s1   <= (PP + GH)'(sc[2*PP-1:PP]) * (PP + GH)'(g[sppf_pkg::G_W-1:PP]);
			neg_s1  <= neg;
			a_s2    <= AW'(ll_s1) + AW'({hl_s1, {PP{1'b0}}});
			b_s2    <= BW'(lh_s1) + BW'({hh_s1, {PP{1'b0}}});
			neg_s2  <= neg_s1;
			prod_s3 <= PW'(a_s2) + PW'({b_s2, {PP{1'b0}}});
			neg_s3  <= neg_s2;
			f_s4    <= neg_s3 ? sppf_pkg::F_W'(-magc) : magc[sppf_pkg::F_W-1:0];
			sat_s4  <= ovf;
		end
	end

	assign f   = f_s4;
	assign sat = sat_s4;

endmodule

// ===== hw/rtl/sph_pressure_pair_force_top.sv =====
// SPH pair pressure force, fixed point.
// pair: one neighbor pair per word (positions Q12.8, mass Q8.8, density Q16.16,
//   pressure terms Q18.14), valid/ready. result: one word per pair, force_x/y
//   Q32.16 saturated, plus zero-density and saturation flags, valid/ready.
// cfg_we/cfg_wdata write the cutoff h (Q11.8); write only while the pipe is empty.
// Throughput: one pair per cycle sustained while the pipe is not frozen (see Stall).
// Pipeline from accept to result valid: 3 front stages (difference,
//   squares, range test), a 28-stage square root, a 64-stage divider for d/h and
//   v/d, 5 multiply stages for (1-d/h)^4, a second 64-stage divider for /h, a
//   4-stage split 64x55 product with clamp, and the output register.
// Reset clears all valid bits and sets h to 50.0.
// Stall: when the result is held and the last stage is occupied the whole pipe
//   freezes; otherwise words keep entering and bubbles collapse toward the output.
module sph_pressure_pair_force_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sppf_pkg::H_W-1:0]    cfg_wdata,
	sppf_pair_if.sink                   pair,
	sppf_result_if.source               result
);

	localparam int MAG_W = sppf_pkg::MAG_W;
	localparam int FR_W  = sppf_pkg::FR_W;
	localparam int NW    = sppf_pkg::DIV_N_W;
	localparam int DW    = sppf_pkg::DIV_D_W;

	logic [sppf_pkg::H_W-1:0]    cutoff_q;
	logic [sppf_pkg::HSQ_W-1:0]  hsq_q;
	logic                        en, load_out;

	// front
	logic [MAG_W:0]              vx_d, vy_d;
	logic [sppf_pkg::PS_W-1:0]   psum_d;
	logic [MAG_W-1:0]            axv_s1, ayv_s1, axv_s2, ayv_s2, axv_s3, ayv_s3;
	logic                        negx_s1, negy_s1, psneg_s1, v_s1;
	logic                        negx_s2, negy_s2, psneg_s2, v_s2;
	logic [sppf_pkg::PS_W-1:0]   aps_s1;
	logic [sppf_pkg::MASS_W-1:0] mass_s1;
	logic [sppf_pkg::DENS_W-1:0] dens_s1, dens_s2, dens_s3;
	logic [2*MAG_W-1:0]          sqx_s2, sqy_s2;
	logic [sppf_pkg::MP_W-1:0]   mp_s2;
	logic                        zden_s2, oor_s2;
	logic [sppf_pkg::D2_W-1:0]   d2;
	logic [sppf_pkg::SQ_IN_W-1:0] rad_s3;
	logic [NW-1:0]               numsc_s3;
	sppf_pkg::ctl_t              ctl_s3;

	// delay lines
	sppf_pkg::ctl_t              ctl_dl [sppf_pkg::CTL_LAT];
	logic [MAG_W-1:0]            avx_dl [sppf_pkg::SQ_LAT];
	logic [MAG_W-1:0]            avy_dl [sppf_pkg::SQ_LAT];
	logic [NW-1:0]               sc_dl  [sppf_pkg::SC_DLY];

	logic [sppf_pkg::SQ_OUT_W-1:0] root;
	logic [NW-1:0]               sc_quo, r_quo, cx_quo, cy_quo, gx_quo, gy_quo;
	logic [FR_W-1:0]             s_s4, s2_s5, s4_s6;
	logic [FR_W-1:0]             cx_s4, cy_s4, cx_s5, cy_s5, cx_s6, cy_s6, ex_s7, ey_s7;
	logic [sppf_pkg::GX5_W-1:0]  ex5, ey5;
	logic [sppf_pkg::G_W-1:0]    ngx_s8, ngy_s8;
	sppf_pkg::ctl_t              ctl_mul, ctl_last;
	logic [sppf_pkg::F_W-1:0]    fx, fy;
	logic                        satx, saty, zero_f;

	logic                        out_v_q, zden_q, sat_q;
	logic [sppf_pkg::F_W-1:0]    fx_q, fy_q;

	assign ctl_mul  = ctl_dl[sppf_pkg::MUL_TAP];
	assign ctl_last = ctl_dl[sppf_pkg::CTL_LAT-1];
	assign load_out = !out_v_q || result.ready;
	assign en       = !ctl_last.v || load_out;
	assign pair.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= sppf_pkg::CUTOFF_RST;
			hsq_q    <= sppf_pkg::HSQ_RST;
		end else begin
			if (cfg_we) begin
				cutoff_q <= cfg_wdata;
			end
			hsq_q <= sppf_pkg::HSQ_W'(cutoff_q) * sppf_pkg::HSQ_W'(cutoff_q);
		end
	end

	always_comb begin
		vx_d   = {pair.pos_j_x[MAG_W-1], pair.pos_j_x} - {pair.pos_i_x[MAG_W-1], pair.pos_i_x};
		vy_d   = {pair.pos_j_y[MAG_W-1], pair.pos_j_y} - {pair.pos_i_y[MAG_W-1], pair.pos_i_y};
		psum_d = {pair.pressure_ratio_i[sppf_pkg::PR_W-1], pair.pressure_ratio_i}
			+ {pair.pressure_ratio_j[sppf_pkg::PR_W-1], pair.pressure_ratio_j};
		d2     = sppf_pkg::D2_W'(sqx_s2) + sppf_pkg::D2_W'(sqy_s2);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			ctl_s3 <= '0;
			for (int k = 0; k < sppf_pkg::CTL_LAT; k++) begin
				ctl_dl[k] <= '0;
			end
		end else if (en) begin
			v_s1         <= pair.valid;
			v_s2         <= v_s1;
			ctl_s3.v     <= v_s2;
			ctl_s3.negx  <= negx_s2;
			ctl_s3.negy  <= negy_s2;
			ctl_s3.psneg <= psneg_s2;
			ctl_s3.zden  <= zden_s2;
			ctl_s3.kill  <= oor_s2 || (d2 == '0) || (d2 >= sppf_pkg::D2_W'(hsq_q));
			ctl_dl[0]    <= ctl_s3;
			for (int k = 1; k < sppf_pkg::CTL_LAT; k++) begin
				ctl_dl[k] <= ctl_dl[k-1];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			axv_s1   <= vx_d[MAG_W] ? MAG_W'(-vx_d) : vx_d[MAG_W-1:0];
			ayv_s1   <= vy_d[MAG_W] ? MAG_W'(-vy_d) : vy_d[MAG_W-1:0];
			negx_s1  <= vx_d[MAG_W];
			negy_s1  <= vy_d[MAG_W];
			aps_s1   <= psum_d[sppf_pkg::PS_W-1] ? -psum_d : psum_d;
			psneg_s1 <= psum_d[sppf_pkg::PS_W-1];
			mass_s1  <= pair.mass_j;
			dens_s1  <= pair.density_j;

			sqx_s2   <= (2 * MAG_W)'(axv_s1) * (2 * MAG_W)'(axv_s1);
			sqy_s2   <= (2 * MAG_W)'(ayv_s1) * (2 * MAG_W)'(ayv_s1);
			mp_s2    <= sppf_pkg::MP_W'(mass_s1) * sppf_pkg::MP_W'(aps_s1);
			zden_s2  <= dens_s1 == '0;
			oor_s2   <= (cutoff_q == '0) || (axv_s1 >= MAG_W'(cutoff_q))
				|| (ayv_s1 >= MAG_W'(cutoff_q));
			axv_s2   <= axv_s1;
			ayv_s2   <= ayv_s1;
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			psneg_s2 <= psneg_s1;
			dens_s2  <= dens_s1;

			rad_s3   <= {d2[sppf_pkg::SQ_IN_W-sppf_pkg::RAD_SH-1:0], {sppf_pkg::RAD_SH{1'b0}}};
			numsc_s3 <= {mp_s2[NW-sppf_pkg::SC_SH-1:0], {sppf_pkg::SC_SH{1'b0}}};
			dens_s3  <= dens_s2;
			axv_s3   <= axv_s2;
			ayv_s3   <= ayv_s2;

			avx_dl[0] <= axv_s3;
			avy_dl[0] <= ayv_s3;
			for (int k = 1; k < sppf_pkg::SQ_LAT; k++) begin
				avx_dl[k] <= avx_dl[k-1];
				avy_dl[k] <= avy_dl[k-1];
			end
			sc_dl[0] <= sc_quo;
			for (int k = 1; k < sppf_pkg::SC_DLY; k++) begin
				sc_dl[k] <= sc_dl[k-1];
			end

			s_s4   <= sppf_pkg::FR_ONE - FR_W'(r_quo[sppf_pkg::FR_FRAC-1:0]);
			cx_s4  <= cx_quo[FR_W-1:0];
			cy_s4  <= cy_quo[FR_W-1:0];
			s2_s5  <= sppf_pkg::fr_mul(s_s4, s_s4);
			cx_s5  <= cx_s4;
			cy_s5  <= cy_s4;
			s4_s6  <= sppf_pkg::fr_mul(s2_s5, s2_s5);
			cx_s6  <= cx_s5;
			cy_s6  <= cy_s5;
			ex_s7  <= sppf_pkg::fr_mul(s4_s6, cx_s6);
			ey_s7  <= sppf_pkg::fr_mul(s4_s6, cy_s6);
			ngx_s8 <= {ex5, {sppf_pkg::G_SH{1'b0}}};
			ngy_s8 <= {ey5, {sppf_pkg::G_SH{1'b0}}};
		end
	end

	assign ex5 = sppf_pkg::GX5_W'({ex_s7, 2'b00}) + sppf_pkg::GX5_W'(ex_s7);
	assign ey5 = sppf_pkg::GX5_W'({ey_s7, 2'b00}) + sppf_pkg::GX5_W'(ey_s7);

	sppf_div_pipe u_div_sc (
		.clk (clk), .en (en), .num (numsc_s3), .den (dens_s3), .quo (sc_quo)
	);

	sppf_sqrt_pipe u_sqrt (
		.clk (clk), .en (en), .rad (rad_s3), .root (root)
	);

	sppf_div_pipe u_div_r (
		.clk (clk), .en (en),
		.num (NW'({root, {sppf_pkg::R_SH{1'b0}}})),
		.den (DW'(cutoff_q)),
		.quo (r_quo)
	);

	sppf_div_pipe u_div_cx (
		.clk (clk), .en (en),
		.num (NW'({avx_dl[sppf_pkg::SQ_LAT-1], {sppf_pkg::C_SH{1'b0}}})),
		.den (DW'(root)),
		.quo (cx_quo)
	);

	sppf_div_pipe u_div_cy (
		.clk (clk), .en (en),
		.num (NW'({avy_dl[sppf_pkg::SQ_LAT-1], {sppf_pkg::C_SH{1'b0}}})),
		.den (DW'(root)),
		.quo (cy_quo)
	);

	sppf_div_pipe u_div_gx (
		.clk (clk), .en (en), .num (NW'(ngx_s8)), .den (DW'(cutoff_q)), .quo (gx_quo)
	);

	sppf_div_pipe u_div_gy (
		.clk (clk), .en (en), .num (NW'(ngy_s8)), .den (DW'(cutoff_q)), .quo (gy_quo)
	);

	sppf_force_mul u_mul_x (
		.clk (clk), .en (en),
		.sc  (sc_dl[sppf_pkg::SC_DLY-1]),
		.g   (gx_quo[sppf_pkg::G_W-1:0]),
		.neg (ctl_mul.psneg == ctl_mul.negx),
		.f   (fx), .sat (satx)
	);

	sppf_force_mul u_mul_y (
		.clk (clk), .en (en),
		.sc  (sc_dl[sppf_pkg::SC_DLY-1]),
		.g   (gy_quo[sppf_pkg::G_W-1:0]),
		.neg (ctl_mul.psneg == ctl_mul.negy),
		.f   (fy), .sat (saty)
	);

	// output register
	assign zero_f = ctl_last.kill || ctl_last.zden;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= ctl_last.v;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			fx_q   <= zero_f ? '0 : fx;
			fy_q   <= zero_f ? '0 : fy;
			zden_q <= ctl_last.zden;
			sat_q  <= !zero_f && (satx || saty);
		end
	end

	assign result.valid             = out_v_q;
	assign result.force_x           = fx_q;
	assign result.force_y           = fy_q;
	assign result.zero_density_flag = zden_q;
	assign result.saturated_flag    = sat_q;

endmodule

// ===== hw/rtl/sppf_chk.sv =====
module sppf_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             pair_ready,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic signed [sppf_pkg::F_W-1:0]  force_x,
	input logic signed [sppf_pkg::F_W-1:0]  force_y,
	input logic                             zden,
	input logic                             sat
);

	localparam logic [sppf_pkg::F_W-1:0] FMAX = {1'b0, {(sppf_pkg::F_W-1){1'b1}}};
	localparam logic [sppf_pkg::F_W-1:0] FMIN = {1'b1, {(sppf_pkg::F_W-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(force_x) && $stable(force_y))
		else $error("result word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");

	a_zden: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && zden |-> force_x == '0 && force_y == '0 && !sat)
		else $error("zero density with nonzero force");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sat |-> force_x == FMAX || force_x == FMIN
			|| force_y == FMAX || force_y == FMIN)
		else $error("saturation flag without clamped component");

endmodule

bind sph_pressure_pair_force_top sppf_chk u_sppf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pair_ready (pair.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.force_x    (result.force_x),
	.force_y    (result.force_y),
	.zden       (result.zero_density_flag),
	.sat        (result.saturated_flag)
);

// ===== tb/tb_sph_pressure_pair_force_top.sv =====
`timescale 1ns / 100ps

module tb_sph_pressure_pair_force_top;

	localparam int LAT = 169;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic signed [47:0] fx;
		logic signed [47:0] fy;
		logic               zden;
		logic               sat;
	} force_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sppf_pkg::H_W-1:0] cfg_wdata = '0;

	sppf_pair_if   pair();
	sppf_result_if result();

	sph_pressure_pair_force_top DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.pair(pair.sink), .result(result.source)
	);

	always #1 clk = ~clk;

	force_word_t    expected_forces[$];
	logic [18:0]    cutoff = 19'd12800;
	int             mismatches = 0;
	int             idle_cycles = 0;
	int             stall_bias = 0;

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [47:0] axis_force(logic signed [63:0] vc, logic [63:0] sc,
			bit psneg, logic [63:0] s4, logic [63:0] dq, logic [63:0] h, ref bit sat);
		logic [63:0] av, c, e, g, mag, lim;
		logic [127:0] prod;
		bit neg;
		av = vc < 0 ? -vc : vc;
		if (av == 0 || sc == 0) return '0;
		c = (av << 40) / dq;
		e = (s4 * c) >> 32;
		g = ((64'd5 * e) << 20) / h;
		prod = {64'd0, sc} * {64'd0, g};
		neg = (psneg == (vc < 0));
		lim = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
		if (prod[127:64] >= (64'd1 << 50)) begin
			mag = lim;
			sat = 1;
		end else begin
			mag = prod[113:50];
			if (mag > lim) begin
				mag = lim;
				sat = 1;
			end
		end
		return neg ? 48'(-mag) : mag[47:0];
	endfunction

	function automatic force_word_t pair_force(logic signed [19:0] ix, logic signed [19:0] iy,
			logic signed [19:0] jx, logic signed [19:0] jy, logic [15:0] mass,
			logic [31:0] dens, logic signed [31:0] pi, logic signed [31:0] pj);
		force_word_t f;
		logic signed [63:0] vx, vy, psum;
		logic [63:0] ax, ay, d2, dq, r, s, s2, s4, sc, aps, h;
		bit sat;
		f = '0;
		sat = 0;
		h = cutoff;
		vx = 64'(jx) - 64'(ix);
		vy = 64'(jy) - 64'(iy);
		psum = 64'(pi) + 64'(pj);
		ax = vx < 0 ? -vx : vx;
		ay = vy < 0 ? -vy : vy;
		if (dens == 0) begin
			f.zden = 1;
			return f;
		end
		if (h == 0 || ax >= h || ay >= h) return f;
		d2 = ax * ax + ay * ay;
		if (d2 == 0 || d2 >= h * h) return f;
		dq = int_sqrt(d2 << 16);
		r = (dq << 24) / h;
		s = (64'd1 << 32) - r;
		s2 = (s * s) >> 32;
		s4 = (s2 * s2) >> 32;
		aps = psum < 0 ? -psum : psum;
		sc = ((64'(mass) * aps) << 16) / dens;
		f.fx = axis_force(vx, sc, psum < 0, s4, dq, h, sat);
		f.fy = axis_force(vy, sc, psum < 0, s4, dq, h, sat);
		f.sat = sat;
		return f;
	endfunction

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic send_pair(logic signed [19:0] ix, logic signed [19:0] iy,
			logic signed [19:0] jx, logic signed [19:0] jy, logic [15:0] mass,
			logic [31:0] dens, logic signed [31:0] pi, logic signed [31:0] pj,
			bit gaps = 1);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			pair.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		pair.valid <= 1'b1;
		pair.pos_i_x <= ix; pair.pos_i_y <= iy;
		pair.pos_j_x <= jx; pair.pos_j_y <= jy;
		pair.mass_j <= mass; pair.density_j <= dens;
		pair.pressure_ratio_i <= pi; pair.pressure_ratio_j <= pj;
		do @(posedge clk); while (!pair.ready);
		expected_forces = {expected_forces, pair_force(ix, iy, jx, jy, mass, dens, pi, pj)};
		@(negedge clk);
	endtask

	task automatic drain();
		pair.valid <= 1'b0;
		while (expected_forces.size() != 0) @(negedge clk);
		repeat (LAT + 10) @(negedge clk);
	endtask

	task automatic write_cutoff(logic [18:0] h);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		cutoff = h;
	endtask

	task automatic send_random_pair(int mode);
		logic signed [19:0] ix, iy, dx, dy;
		logic [31:0] dens;
		logic [15:0] mass;
		logic signed [31:0] pi, pj;
		int hr;
		ix = 20'($urandom); iy = 20'($urandom);
		hr = (cutoff == 0) ? 1 : int'(cutoff);
		if (mode < 80) begin
			dx = 20'($urandom_range(0, 2 * hr) - hr);
			dy = 20'($urandom_range(0, 2 * hr) - hr);
		end else begin
			dx = 20'($urandom); dy = 20'($urandom);
		end
		mass = 16'($urandom);
		dens = ($urandom_range(0, 19) == 0) ? 32'd0 :
			($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h40000));
		pi = ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 65535)) - 32768);
		pj = ($urandom_range(0, 1)) ? $urandom : 32'($signed($urandom_range(0, 65535)) - 32768);
		send_pair(ix, iy, 20'(ix + dx), 20'(iy + dy), mass, dens, pi, pj);
	endtask

	task automatic test_directed();
		send_pair(0, 0, 0, 0, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		send_pair(0, 0, 256, 0, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		send_pair(0, 0, 0, -256, 16'h0100, 32'h10000, -32'h4000, 32'h4000);
		send_pair(0, 0, 300, 400, 16'hFFFF, 32'd1, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_pair(0, 0, -300, 400, 16'hFFFF, 32'd1, 32'h80000000, 32'h80000000);
		send_pair(0, 0, 12800, 0, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		send_pair(0, 0, 12799, 0, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		send_pair(0, 0, 9000, 9100, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		send_pair(0, 0, 100, 100, 16'h0100, 32'd0, 32'h4000, 32'h4000);
		send_pair(20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 16'hFFFF, 32'hFFFFFFFF,
			32'h7FFFFFFF, 32'h80000000);
		send_pair(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 16'h0, 32'hFFFFFFFF, 0, 0);
		send_pair(5, 5, 6, 5, 16'h0100, 32'h10000, 32'h1234, -32'h1234);
		send_pair(5, 5, 5, 6, 16'h8000, 32'h00000100, 32'h00100000, 32'h00000001);
	endtask

	task automatic test_random(int n);
		repeat (n) send_random_pair($urandom_range(0, 99));
	endtask

	task automatic test_cutoff_settings();
		write_cutoff(19'd1);
		send_pair(0, 0, 0, 0, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		send_pair(0, 0, 1, 0, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		test_random(60);
		write_cutoff(19'd0);
		send_pair(0, 0, 1, 1, 16'h0100, 32'h10000, 32'h4000, 32'h4000);
		test_random(30);
		write_cutoff(19'h7FFFF);
		send_pair(20'h80000, 0, 20'h7FFFF, 0, 16'hFFFF, 32'd1, 32'h7FFFFFFF, 32'h7FFFFFFF);
		test_random(120);
		write_cutoff(19'd700);
		test_random(120);
		write_cutoff(19'h2AAAA);
		test_random(120);
		write_cutoff(19'd12800);
	endtask

	task automatic test_backpressure();
		stall_bias = 1;
		test_random(80);
		stall_bias = 2;
		repeat (100) send_random_pair($urandom_range(0, 99));
		stall_bias = 0;
	endtask

	task automatic test_streaming();
		repeat (80) begin
			send_pair(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
				16'($urandom), $urandom, $urandom, $urandom, 0);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_bias == 2) begin
			result.ready <= 1'b1;
		end else if (stall_bias == 1) begin
			result.ready <= ($urandom_range(0, 99) < 15);
		end else begin
			result.ready <= ($urandom_range(0, 99) < 75);
		end
	end

	always @(posedge clk) begin
		force_word_t exp_w;
		force_word_t got_w;
		if (arst_n && result.valid && result.ready) begin
			got_w = {result.force_x, result.force_y, result.zero_density_flag,
				result.saturated_flag};
			if (expected_forces.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word fx=%h fy=%h", got_w.fx, got_w.fy);
			end else begin
				exp_w = expected_forces.pop_front();
				if (got_w !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp fx=%h fy=%h z=%b s=%b got fx=%h fy=%h z=%b s=%b",
							exp_w.fx, exp_w.fy, exp_w.zden, exp_w.sat,
							got_w.fx, got_w.fy, got_w.zden, got_w.sat);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pair.valid && pair.ready) || (result.valid && result.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_sph_pressure_pair_force_top NOT OK");
			$finish;
		end
	end

	initial begin
		pair.valid = 1'b0;
		pair.pos_i_x = '0; pair.pos_i_y = '0; pair.pos_j_x = '0; pair.pos_j_y = '0;
		pair.mass_j = '0; pair.density_j = '0;
		pair.pressure_ratio_i = '0; pair.pressure_ratio_j = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(30);
		drain();
		test_cutoff_settings();
		test_streaming();
		test_backpressure();
		drain();
		if (mismatches == 0 && expected_forces.size() == 0)
			$display("tb_sph_pressure_pair_force_top OK");
		else
			$display("tb_sph_pressure_pair_force_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sppf_pkg.sv
hw/rtl/sppf_ifs.sv
hw/rtl/sppf_sqrt_pipe.sv
hw/rtl/sppf_div_pipe.sv
hw/rtl/sppf_force_mul.sv
hw/rtl/sph_pressure_pair_force_top.sv
hw/rtl/sppf_chk.sv
tb/tb_sph_pressure_pair_force_top.sv
